[sv/camera_to_world_vector_rotate_defines.svh]
// Assertion macros used by the c2w_checker file.
`ifndef CAMERA_TO_WORLD_VECTOR_ROTATE_DEFINES_SVH
`define CAMERA_TO_WORLD_VECTOR_ROTATE_DEFINES_SVH

// Same-cycle implication.
`define C2W_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("c2w assertion failed");

// Next-cycle implication.
`define C2W_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("c2w assertion failed");

`endif

[sv/c2w_pkg.sv]
// ----------------------------------------------------------------------------
// c2w_pkg
// Widths, register indexes and saturation limits for the vector rotator.
// ----------------------------------------------------------------------------
package c2w_pkg;

   localparam int COORD_W    = 32;                 // Q16.16 vector / offset
   localparam int QUAT_W     = 16;                 // Q1.15 quaternion part
   localparam int VEC_W      = COORD_W + 1;        // remapped axis, may be +2^31
   localparam int UV_W       = QUAT_W + VEC_W;     // u_i * v_j
   localparam int SQ_W       = 2 * QUAT_W;         // w*w, u_i*u_i
   localparam int DOT_W      = UV_W + 1;           // u . v
   localparam int CRS_W      = UV_W;               // (u x v)_i
   localparam int A_W        = SQ_W + 1;           // w^2 - |u|^2
   localparam int T1_W       = A_W + VEC_W;
   localparam int T2_W       = DOT_W + QUAT_W;
   localparam int T3_W       = CRS_W + QUAT_W;
   localparam int SUM_W      = T1_W + 2;
   localparam int ROUND_SHIFT = 30;                // Q1.15 * Q1.15 fraction
   localparam int RND_W      = SUM_W - ROUND_SHIFT;
   localparam int OFS_SUM_W  = RND_W + 1;
   localparam int NUM_STAGES = 5;

   localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [QUAT_W-1:0]  ROT_W_RESET = {1'b0, {(QUAT_W-1){1'b1}}};

   typedef enum logic [2:0] {
      CSR_ROT_X        = 3'd0,
      CSR_ROT_Y        = 3'd1,
      CSR_ROT_Z        = 3'd2,
      CSR_ROT_W        = 3'd3,
      CSR_OFFSET_EAST  = 3'd4,
      CSR_OFFSET_NORTH = 3'd5,
      CSR_OFFSET_UP    = 3'd6
   } csr_index_type;

   typedef logic signed [COORD_W-1:0] coord_type;

endpackage

[sv/camera_to_world_vector_rotate.sv]
// ----------------------------------------------------------------------------
// camera_to_world_vector_rotate
// Remaps a camera vector to body axes, rotates it by q v q* and adds the
// world offset for positions, saturating each component to 32 bits.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  req     | in        | req_valid/req_ready  | cam_right/down/forward, is_point
//  rsp     | out       | rsp_valid/rsp_ready  | world_x/y/z, saturated
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One request per cycle unless a full pipe is held by a stalled response; five register
// stages (small products, sums, wide products, rounding, offset and clip).
// Each stage holds only while it is full and the stage after it is stalled,
// so bubbles close up and requests are taken while a response waits.
// Reset clears the stage valid bits and loads register defaults (w near one).
// csr writes are always accepted; unknown indexes are dropped.
//
module camera_to_world_vector_rotate import c2w_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [31:0]       req_cam_right,
   input  logic [31:0]       req_cam_down,
   input  logic [31:0]       req_cam_forward,
   input  logic              req_is_point,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_world_x,
   output logic [31:0]       rsp_world_y,
   output logic [31:0]       rsp_world_z,
   output logic              rsp_saturated,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data
);

   // ---------------- configuration registers ----------------
   logic signed [QUAT_W-1:0]  u_ff [3];      // rot_x, rot_y, rot_z
   logic signed [QUAT_W-1:0]  w_ff;
   coord_type                 offs_ff [3];   // east, north, up

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            u_ff[i]    <= '0;
            offs_ff[i] <= '0;
         end
         w_ff <= ROT_W_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ROT_X:        u_ff[0]    <= csr_data[QUAT_W-1:0];
            CSR_ROT_Y:        u_ff[1]    <= csr_data[QUAT_W-1:0];
            CSR_ROT_Z:        u_ff[2]    <= csr_data[QUAT_W-1:0];
            CSR_ROT_W:        w_ff       <= csr_data[QUAT_W-1:0];
            CSR_OFFSET_EAST:  offs_ff[0] <= csr_data;
            CSR_OFFSET_NORTH: offs_ff[1] <= csr_data;
            CSR_OFFSET_UP:    offs_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- stage flow control ----------------
   // rdy[k]: stage k register may load this cycle.
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] rdy;

   always_comb begin
      rdy[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // ---------------- stage 1: remap and small products ----------------
   // body axes: v0 = forward, v1 = -right (left), v2 = -down (up)
   logic signed [VEC_W-1:0] v_in [3];
   logic signed [VEC_W-1:0] v1_ff [3];
   logic signed [UV_W-1:0]  uv_ff [3][3];   // [u index][v index]
   logic signed [SQ_W-1:0]  ww_ff;
   logic signed [SQ_W-1:0]  uu_ff [3];
   logic                    pt1_ff;

   always_comb begin
      v_in[0] = {req_cam_forward[31], req_cam_forward};
      v_in[1] = -{req_cam_right[31], req_cam_right};
      v_in[2] = -{req_cam_down[31], req_cam_down};
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         for (int i = 0; i < 3; i++) begin
            v1_ff[i] <= v_in[i];
            uu_ff[i] <= SQ_W'(u_ff[i]) * SQ_W'(u_ff[i]);
            for (int j = 0; j < 3; j++) begin
               uv_ff[i][j] <= UV_W'(u_ff[i]) * UV_W'(v_in[j]);
            end
         end
         ww_ff  <= SQ_W'(w_ff) * SQ_W'(w_ff);
         pt1_ff <= req_is_point;
      end
   end

   // ---------------- stage 2: dot, cross, scalar term ----------------
   logic signed [VEC_W-1:0] v2_ff [3];
   logic signed [DOT_W-1:0] dot_ff;
   logic signed [CRS_W-1:0] crs_ff [3];
   logic signed [A_W-1:0]   a_ff;
   logic                    pt2_ff;

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         v2_ff     <= v1_ff;
         dot_ff    <= DOT_W'(uv_ff[0][0]) + DOT_W'(uv_ff[1][1]) + DOT_W'(uv_ff[2][2]);
         crs_ff[0] <= uv_ff[1][2] - uv_ff[2][1];
         crs_ff[1] <= uv_ff[2][0] - uv_ff[0][2];
         crs_ff[2] <= uv_ff[0][1] - uv_ff[1][0];
         a_ff      <= A_W'(ww_ff) - A_W'(uu_ff[0]) - A_W'(uu_ff[1]) - A_W'(uu_ff[2]);
         pt2_ff    <= pt1_ff;
      end
   end

   // ---------------- stage 3: wide products ----------------
   logic signed [T1_W-1:0] t1_ff [3];   // a * v_i
   logic signed [T2_W-1:0] t2_ff [3];   // (u.v) * u_i
   logic signed [T3_W-1:0] t3_ff [3];   // w * (u x v)_i
   logic                   pt3_ff;

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         for (int i = 0; i < 3; i++) begin
            t1_ff[i] <= T1_W'(a_ff) * T1_W'(v2_ff[i]);
            t2_ff[i] <= T2_W'(dot_ff) * T2_W'(u_ff[i]);
            t3_ff[i] <= T3_W'(w_ff) * T3_W'(crs_ff[i]);
         end
         pt3_ff <= pt2_ff;
      end
   end

   // ---------------- stage 4: sum and round half up ----------------
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (ROUND_SHIFT - 1);

   logic signed [SUM_W-1:0] sum_in [3];
   logic signed [RND_W-1:0] rnd_ff [3];
   logic                    pt4_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = SUM_W'(t1_ff[i]) + (SUM_W'(t2_ff[i]) <<< 1)
                   + (SUM_W'(t3_ff[i]) <<< 1) + ROUND_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         for (int i = 0; i < 3; i++) begin
            rnd_ff[i] <= RND_W'(sum_in[i] >>> ROUND_SHIFT);
         end
         pt4_ff <= pt3_ff;
      end
   end

   // ---------------- stage 5: offset and saturate ----------------
   logic signed [OFS_SUM_W-1:0] ofs_sum [3];
   logic [2:0]                  clip;
   coord_type                   res_in [3];
   coord_type                   res_ff [3];
   logic                        sat_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ofs_sum[i] = OFS_SUM_W'(rnd_ff[i])
                    + (pt4_ff ? OFS_SUM_W'(offs_ff[i]) : OFS_SUM_W'(0));
         // in range when every bit above the sign bit matches it
         clip[i] = !((&ofs_sum[i][OFS_SUM_W-1:COORD_W-1]) ||
                     !(|ofs_sum[i][OFS_SUM_W-1:COORD_W-1]));
         if (clip[i]) begin
            res_in[i] = ofs_sum[i][OFS_SUM_W-1] ? SAT_MIN : SAT_MAX;
         end else begin
            res_in[i] = ofs_sum[i][COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         res_ff <= res_in;
         sat_ff <= |clip;
      end
   end

   assign rsp_world_x   = res_ff[0];
   assign rsp_world_y   = res_ff[1];
   assign rsp_world_z   = res_ff[2];
   assign rsp_saturated = sat_ff;

endmodule

[sv/c2w_checker.sv]
// ----------------------------------------------------------------------------
// c2w_checker
// Port-level checks of the vector rotator, bound to the top level.
// ----------------------------------------------------------------------------
`include "camera_to_world_vector_rotate_defines.svh"

module c2w_checker import c2w_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_world_x,
   input logic [31:0] rsp_world_y,
   input logic [31:0] rsp_world_z,
   input logic        rsp_saturated
);

   logic at_limit;

   assign at_limit = (rsp_world_x == SAT_MAX) || (rsp_world_x == SAT_MIN) ||
                     (rsp_world_y == SAT_MAX) || (rsp_world_y == SAT_MIN) ||
                     (rsp_world_z == SAT_MAX) || (rsp_world_z == SAT_MIN);

   // stalled response holds
   `C2W_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_world_x) && $stable(rsp_world_y) && $stable(rsp_world_z) && $stable(rsp_saturated))

   // input side only backs up when every stage is full and the output stalls
   `C2W_ASSERT_SAME(a_req_backpressure, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   // a clip flag always comes with a component pinned at a limit
   `C2W_ASSERT_SAME(a_sat_at_limit, clock, reset, rsp_valid && rsp_saturated, at_limit)

   // reset empties the pipeline
   `C2W_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind camera_to_world_vector_rotate c2w_checker u_c2w_checker (.*);

[test/camera_to_world_vector_rotate_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_to_world_vector_rotate_checker
// Watches the request, response and csr channels of the vector rotator,
// keeps its own copy of the quaternion and offsets, predicts each world
// vector exactly and compares responses in order, field by field.
// ----------------------------------------------------------------------------
module camera_to_world_vector_rotate_checker import c2w_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_cam_right,
   input  logic [31:0] req_cam_down,
   input  logic [31:0] req_cam_forward,
   input  logic        req_is_point,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_world_x,
   input  logic [31:0] rsp_world_y,
   input  logic [31:0] rsp_world_z,
   input  logic        rsp_saturated,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending_results
);

   // wide enough for the exact sum of all three rotation terms
   typedef logic signed [95:0] wide_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      sat;
   } world_result_type;

   localparam wide_type HALF_LSB = wide_type'(1) <<< (ROUND_SHIFT - 1);

   logic signed [QUAT_W-1:0] q_x, q_y, q_z, q_w;
   coord_type                ofs_east, ofs_north, ofs_up;
   world_result_type         expected_world[$];
   int                       mismatches = 0;

   assign fail_count = mismatches;

   function automatic world_result_type predict_world(coord_type right, coord_type down,
                                                       coord_type forward, logic point);
      wide_type         v[3];
      wide_type         u[3];
      wide_type         c[3];
      wide_type         ofs[3];
      wide_type         w, a, d, t, r;
      coord_type        comp[3];
      logic             sat;
      world_result_type res;
      int               i;
      // camera (right, down, forward) -> body (forward, left, up)
      v[0] = forward;
      v[1] = right;
      v[1] = -v[1];
      v[2] = down;
      v[2] = -v[2];
      u[0] = q_x;
      u[1] = q_y;
      u[2] = q_z;
      w    = q_w;
      ofs[0] = ofs_east;
      ofs[1] = ofs_north;
      ofs[2] = ofs_up;
      a = w * w - (u[0] * u[0] + u[1] * u[1] + u[2] * u[2]);
      d = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
      c[0] = u[1] * v[2] - u[2] * v[1];
      c[1] = u[2] * v[0] - u[0] * v[2];
      c[2] = u[0] * v[1] - u[1] * v[0];
      sat = 1'b0;
      for (i = 0; i < 3; i++) begin
         t = a * v[i] + 2 * d * u[i] + 2 * w * c[i];
         r = (t + HALF_LSB) >>> ROUND_SHIFT;   // round half up
         if (point) r = r + ofs[i];
         if (r > SAT_MAX) begin
            r   = SAT_MAX;
            sat = 1'b1;
         end else if (r < SAT_MIN) begin
            r   = SAT_MIN;
            sat = 1'b1;
         end
         comp[i] = r[COORD_W-1:0];
      end
      res.x   = comp[0];
      res.y   = comp[1];
      res.z   = comp[2];
      res.sat = sat;
      return res;
   endfunction

   always @(posedge clock) begin
      world_result_type want;
      if (reset) begin
         q_x       <= '0;
         q_y       <= '0;
         q_z       <= '0;
         q_w       <= ROT_W_RESET;
         ofs_east  <= '0;
         ofs_north <= '0;
         ofs_up    <= '0;
         expected_world.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_ROT_X:        q_x       <= csr_data[QUAT_W-1:0];
               CSR_ROT_Y:        q_y       <= csr_data[QUAT_W-1:0];
               CSR_ROT_Z:        q_z       <= csr_data[QUAT_W-1:0];
               CSR_ROT_W:        q_w       <= csr_data[QUAT_W-1:0];
               CSR_OFFSET_EAST:  ofs_east  <= csr_data;
               CSR_OFFSET_NORTH: ofs_north <= csr_data;
               CSR_OFFSET_UP:    ofs_up    <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_world.size() == 0) begin
               $error("response with no request outstanding: world_x %0d",
                      $signed(rsp_world_x));
               mismatches++;
            end else begin
               want = expected_world.pop_front();
               if (want.x !== rsp_world_x) begin
                  $error("world_x mismatch: expected %0d, actual %0d",
                         want.x, $signed(rsp_world_x));
                  mismatches++;
               end
               if (want.y !== rsp_world_y) begin
                  $error("world_y mismatch: expected %0d, actual %0d",
                         want.y, $signed(rsp_world_y));
                  mismatches++;
               end
               if (want.z !== rsp_world_z) begin
                  $error("world_z mismatch: expected %0d, actual %0d",
                         want.z, $signed(rsp_world_z));
                  mismatches++;
               end
               if (want.sat !== rsp_saturated) begin
                  $error("saturated mismatch: expected %0b, actual %0b",
                         want.sat, rsp_saturated);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_world.insert(expected_world.size(),
                                  predict_world(req_cam_right, req_cam_down,
                                                req_cam_forward, req_is_point));
      end
      pending_results = expected_world.size();
   end

endmodule

[test/camera_to_world_vector_rotate_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_to_world_vector_rotate_tb
// Drives camera vectors and quaternion/offset settings into the rotator with
// random idle on both channels; the checker beside the block predicts and
// compares every response, and this top gives the verdict.
// ----------------------------------------------------------------------------
module camera_to_world_vector_rotate_tb;
   import c2w_pkg::*;

   localparam int       PHASES          = 8;
   localparam int       ITEMS_PER_PHASE = 144;
   localparam int       HOLD_CYCLES     = 40;     // long receiver stall
   localparam logic [2:0] CSR_SPARE     = 3'd7;   // index with no register

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_cam_right;
   logic [31:0] req_cam_down;
   logic [31:0] req_cam_forward;
   logic        req_is_point;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_world_x;
   logic [31:0] rsp_world_y;
   logic [31:0] rsp_world_z;
   logic        rsp_saturated;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   int          fail_count;
   int          pending_results;

   // idle odds in percent, changed per phase by the stimulus process
   int unsigned send_idle_pct = 22;
   int unsigned recv_idle_pct = 82;
   bit          hold_off_req  = 1'b0;

   camera_to_world_vector_rotate u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cam_right   (req_cam_right),
      .req_cam_down    (req_cam_down),
      .req_cam_forward (req_cam_forward),
      .req_is_point    (req_is_point),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_world_x     (rsp_world_x),
      .rsp_world_y     (rsp_world_y),
      .rsp_world_z     (rsp_world_z),
      .rsp_saturated   (rsp_saturated),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   camera_to_world_vector_rotate_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cam_right   (req_cam_right),
      .req_cam_down    (req_cam_down),
      .req_cam_forward (req_cam_forward),
      .req_is_point    (req_is_point),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_world_x     (rsp_world_x),
      .rsp_world_y     (rsp_world_y),
      .rsp_world_z     (rsp_world_z),
      .rsp_saturated   (rsp_saturated),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Response side: random back-pressure, plus one long hold on demand so
   // the pipe fills up and pushes back on requests.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end
         rsp_ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Mix of extremes, full-range and moderate values; moderate ones keep
   // most results out of saturation so the rotation itself gets checked.
   function automatic coord_type rand_coord();
      case ($urandom_range(9))
         0:       return SAT_MIN;
         1:       return SAT_MAX;
         2, 3:    return coord_type'($urandom);
         default: return coord_type'($urandom_range(0, 32'h003F_FFFF))
                         - coord_type'(32'h0020_0000);
      endcase
   endfunction

   // Called at a falling edge, returns at a falling edge. Each cycle idles
   // with the sender's odds; valid stays high across back-to-back requests
   // when no idle cycle is drawn.
   task automatic send_request(coord_type right, coord_type down, coord_type forward,
                               logic point);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_cam_right   = right;
      req_cam_down    = down;
      req_cam_forward = forward;
      req_is_point    = point;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      req_valid = 1'b0;
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Drop req_valid, wait for every expected response, then let the pipe idle.
   task automatic drain();
      req_valid = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (2 * NUM_STAGES) @(negedge clock);
   endtask

   // Writes all seven registers. Quaternion writes carry random junk in the
   // upper half of the data word, which the block must drop.
   task automatic apply_setting(int unsigned sel);
      logic signed [QUAT_W-1:0] rx, ry, rz, rw;
      coord_type                off_e, off_n, off_u;
      rx    = QUAT_W'($urandom);
      ry    = QUAT_W'($urandom);
      rz    = QUAT_W'($urandom);
      rw    = QUAT_W'($urandom);
      off_e = rand_coord();
      off_n = rand_coord();
      off_u = rand_coord();
      case (sel)
         1: begin                          // most negative everywhere
            rx = '1 << (QUAT_W - 1); ry = rx; rz = rx; rw = rx;
            off_e = SAT_MIN; off_n = SAT_MIN; off_u = SAT_MIN;
         end
         2: begin                          // most positive everywhere
            rx = ROT_W_RESET; ry = rx; rz = rx; rw = rx;
            off_e = SAT_MAX; off_n = SAT_MAX; off_u = SAT_MAX;
         end
         3: begin                          // zero quaternion: only offsets left
            rx = '0; ry = '0; rz = '0; rw = '0;
         end
         4: begin                          // quarter turn about up
            rx = '0; ry = '0; rz = 16'sd23170; rw = 16'sd23170;
         end
         6: begin                          // direction-only world
            off_e = '0; off_n = '0; off_u = '0;
         end
         7: begin                          // w = -1, vector part zero
            rx = '0; ry = '0; rz = '0; rw = '1 << (QUAT_W - 1);
         end
         default: ;
      endcase
      write_reg(CSR_ROT_X,        {16'($urandom), rx});
      write_reg(CSR_ROT_Y,        {16'($urandom), ry});
      write_reg(CSR_ROT_Z,        {16'($urandom), rz});
      write_reg(CSR_ROT_W,        {16'($urandom), rw});
      write_reg(CSR_OFFSET_EAST,  off_e);
      write_reg(CSR_OFFSET_NORTH, off_n);
      write_reg(CSR_OFFSET_UP,    off_u);
   endtask

   initial begin
      int p;
      int n;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cam_right   = '0;
      req_cam_down    = '0;
      req_cam_forward = '0;
      req_is_point    = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = CSR_ROT_X;
      csr_data        = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed: reset setting (w just under one, no offset) ---
      send_request('0, '0, '0, 1'b0);
      send_request(SAT_MIN, SAT_MIN, SAT_MIN, 1'b0);   // negation hits +2^31
      send_request(SAT_MAX, SAT_MAX, SAT_MAX, 1'b1);
      send_request(-32'sd1, 32'sd1, -32'sd1, 1'b0);
      send_request(SAT_MIN, SAT_MAX, '0, 1'b1);
      send_request(SAT_MAX, SAT_MIN, SAT_MIN, 1'b1);
      send_request(32'sd1, -32'sd1, 32'sd1, 1'b0);
      send_request(32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F, 1'b1);
      drain();

      // write to an index with no register behind it: must change nothing
      write_reg(CSR_SPARE, 32'hFFFF_FFFF);
      send_request(32'sd65536, -32'sd65536, 32'sd65536, 1'b1);
      drain();

      // --- directed: exact ties in the rounding (w = 2^-8, scale 2^-16) ---
      write_reg(CSR_ROT_X, '0);
      write_reg(CSR_ROT_Y, '0);
      write_reg(CSR_ROT_Z, '0);
      write_reg(CSR_ROT_W, 32'd128);
      send_request('0, '0, 32'sd32768, 1'b0);     // +0.5 lsb rounds up
      send_request('0, '0, -32'sd32768, 1'b0);    // -0.5 lsb rounds up to zero
      send_request(32'sd32768, '0, '0, 1'b0);
      send_request('0, -32'sd32768, '0, 1'b1);
      drain();

      // --- directed: most negative quaternion, largest offsets ---
      apply_setting(1);
      send_request(SAT_MIN, SAT_MIN, SAT_MIN, 1'b1);
      send_request(SAT_MAX, SAT_MAX, SAT_MAX, 1'b1);
      send_request(SAT_MAX, SAT_MIN, SAT_MAX, 1'b0);
      send_request('0, '0, '0, 1'b1);
      drain();

      // --- random phases, one register setting each ---
      for (p = 0; p < PHASES; p++) begin
         if (p < 3) begin
            send_idle_pct = 22;
            recv_idle_pct = 82;
         end else if (p < 6) begin
            send_idle_pct = 82;
            recv_idle_pct = 22;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         apply_setting(p);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // with no idle on either side, a long receiver stall backs the
            // pipe up into the request channel
            if (p == PHASES - 2 && n == 30)
               hold_off_req = 1'b1;
            send_request(rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
         end
         drain();
      end

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
